@@ design/fat12_pkg.sv @@
// Shared types and constants for the FAT12 cluster chain engine.
// No dependencies.
package fat12_pkg;

  localparam logic [2:0] MODE_WR_BYTE  = 3'd0;
  localparam logic [2:0] MODE_RD_BYTE  = 3'd1;
  localparam logic [2:0] MODE_RD_ENTRY = 3'd2;
  localparam logic [2:0] MODE_WR_ENTRY = 3'd3;
  localparam logic [2:0] MODE_FREE     = 3'd4;
  localparam logic [2:0] MODE_ALLOC    = 3'd5;
  localparam logic [2:0] MODE_COLLECT  = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_DATA = 2'd1;
  localparam logic [1:0] ST_BROKEN   = 2'd2;
  localparam logic [1:0] ST_NO_SPACE = 2'd3;

  localparam logic [11:0] BAD_MARK  = 12'hFF7;
  localparam logic [11:0] END_MIN   = 12'hFF8;
  localparam logic [11:0] END_MARK  = 12'hFFF;
  localparam logic [11:0] MAX_DATA  = 12'd4084;

  // Datapath commands.
  typedef enum logic [3:0] {
    DP_NONE    = 4'd0,
    DP_LATCH   = 4'd1,  // capture item fields
    DP_RD_LO   = 4'd2,  // read byte at entry offset of cur
    DP_RD_HI   = 4'd3,  // read byte at offset+1, lo data arrives
    DP_WR_LO   = 4'd4,  // write lo byte of entry cur with wval
    DP_WR_HI   = 4'd5,  // write hi byte of entry cur with wval
    DP_BYTE_WR = 4'd6,
    DP_BYTE_RD = 4'd7,
    DP_CAP     = 4'd8   // capture assembled entry
  } dp_cmd_e;

  // Value selection for entry writes.
  typedef enum logic [1:0] {
    WV_INPUT = 2'd0,
    WV_ZERO  = 2'd1,
    WV_LINK  = 2'd2,  // cluster of scan pointer
    WV_END   = 2'd3
  } wv_sel_e;

  // Cluster pointer selection.
  typedef enum logic [2:0] {
    CP_HOLD  = 3'd0,
    CP_INPUT = 3'd1,  // item cluster
    CP_NEXT  = 3'd2,  // last read entry
    CP_SCAN  = 3'd3,  // scan pointer
    CP_PREV  = 3'd4
  } cp_sel_e;

  typedef struct packed {
    dp_cmd_e cmd;
    wv_sel_e wv;
    cp_sel_e cp;
    logic    scan_init;  // scan <- 2
    logic    scan_inc;
    logic    prev_load;  // prev <- scan
    logic    len_clr;
    logic    len_inc;
    logic    found_clr;
    logic    found_inc;
    logic    first_load; // first <- scan
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] entry;     // last captured entry
    logic        cur_zero;
    logic        cur_data;
    logic        scan_in;   // scan pointer within data clusters
    logic        len_full;  // len == total
    logic        found_done;
    logic        found_zero;
  } dp_sts_t;

endpackage

@@ design/fat12_datapath.sv @@
// Datapath of the FAT12 engine: table memory, entry packing, pointers.
// Depends on fat12_pkg.
module fat12_datapath import fat12_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic        clk,
  input  dp_ctl_t     ctl,
  input  logic [2:0]  in_mode,
  input  logic [12:0] in_byte_addr,
  input  logic [11:0] in_cluster,
  input  logic [11:0] in_value,
  input  logic [11:0] in_count,
  input  logic [11:0] total,
  output dp_sts_t     sts,
  output logic [11:0] byte_rd,
  output logic [11:0] cluster_q,
  output logic [11:0] first_q,
  output logic [11:0] len_q
);
  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rdata_r;

  logic [2:0]  mode_r;
  logic [12:0] baddr_r;
  logic [11:0] clus_r, val_r, cnt_r;
  logic [11:0] cur_r, cur_nxt, scan_r, prev_r, first_r, len_r, found_r;
  logic [11:0] entry_r;
  logic [7:0]  lo_r;

  logic [12:0] off;
  logic [AW-1:0] a0, a1, addr;
  logic        we;
  logic [7:0]  wdata;
  logic [11:0] wv;

  assign off = ({1'b0, cur_r} + {2'b0, cur_r[11:1]});
  assign a0  = off[AW-1:0];
  assign a1  = AW'(off + 13'd1);

  always_comb begin
    case (ctl.wv)
      WV_INPUT: wv = val_r;
      WV_ZERO:  wv = '0;
      WV_LINK:  wv = scan_r;
      WV_END:   wv = END_MARK;
      default:  wv = '0;
    endcase
  end

  // Read-modify-write of the shared nibble uses the byte read just before.
  always_comb begin
    we = 1'b0;
    addr = a0;
    wdata = '0;
    case (ctl.cmd)
      DP_RD_LO: addr = a0;
      DP_RD_HI: addr = a1;
      DP_WR_LO: begin
        we = 1'b1;
        addr = a0;
        wdata = cur_r[0] ? {wv[3:0], lo_r[3:0]} : wv[7:0];
      end
      DP_WR_HI: begin
        we = 1'b1;
        addr = a1;
        wdata = cur_r[0] ? wv[11:4] : {rdata_r[7:4], wv[11:8]};
      end
      DP_BYTE_WR: begin
        we = 1'b1;
        addr = baddr_r[AW-1:0];
        wdata = val_r[7:0];
      end
      DP_BYTE_RD: addr = baddr_r[AW-1:0];
      default: ;
    endcase
  end

  // Hold read data across a write so the high byte survives for the merge.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    else rdata_r <= mem[addr];
  end

  always_comb begin
    case (ctl.cp)
      CP_INPUT: cur_nxt = clus_r;
      CP_NEXT:  cur_nxt = entry_r;
      CP_SCAN:  cur_nxt = scan_r;
      CP_PREV:  cur_nxt = prev_r;
      default:  cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == DP_LATCH) begin
      mode_r  <= in_mode;
      baddr_r <= in_byte_addr;
      clus_r  <= in_cluster;
      val_r   <= in_value;
      cnt_r   <= in_count;
      cur_r   <= in_cluster;
    end else begin
      cur_r <= cur_nxt;
    end
    if (ctl.cmd == DP_RD_HI) lo_r <= rdata_r;
    if (ctl.cmd == DP_CAP)
      entry_r <= cur_r[0] ? {rdata_r, lo_r[7:4]} : {rdata_r[3:0], lo_r};
    if (ctl.scan_init) scan_r <= 12'd2;
    else if (ctl.scan_inc) scan_r <= scan_r + 12'd1;
    if (ctl.prev_load) prev_r <= scan_r;
    if (ctl.first_load) first_r <= scan_r;
    if (ctl.len_clr) len_r <= '0;
    else if (ctl.len_inc) len_r <= len_r + 12'd1;
    if (ctl.found_clr) found_r <= '0;
    else if (ctl.found_inc) found_r <= found_r + 12'd1;
  end

  logic [11:0] cm2, sm2;
  assign cm2 = cur_r - 12'd2;
  assign sm2 = scan_r - 12'd2;

  always_comb begin
    sts.mode       = mode_r;
    sts.entry      = entry_r;
    sts.cur_zero   = (cur_r == '0);
    sts.cur_data   = (cur_r >= 12'd2) && (cm2 < total);
    sts.scan_in    = (sm2 < total);
    sts.len_full   = (len_r == total);
    sts.found_done = (found_r == cnt_r);
    sts.found_zero = (cnt_r == '0);
  end

  assign byte_rd   = {4'd0, rdata_r};
  assign cluster_q = clus_r;
  assign first_q   = first_r;
  assign len_q     = len_r;
endmodule

@@ design/fat12_ctrl.sv @@
// Controller state machine of the FAT12 engine.
// Depends on fat12_pkg.
module fat12_ctrl import fat12_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  dp_sts_t     sts,
  input  logic [11:0] byte_rd,
  input  logic [11:0] cluster_q,
  input  logic [11:0] first_q,
  input  logic [11:0] len_q,
  output dp_ctl_t     ctl,
  output logic        out_valid,
  output logic [11:0] out_result_value,
  output logic [11:0] out_chain_length,
  output logic [1:0]  out_status
);
  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DISP    = 16'h0002,
    S_BYTE    = 16'h0004,
    S_RLO     = 16'h0008,
    S_RHI     = 16'h0010,
    S_CAP     = 16'h0020,
    S_EVAL    = 16'h0040,
    S_WLO     = 16'h0080,
    S_WHI     = 16'h0100,
    S_WFIN    = 16'h0200,
    S_SCAN    = 16'h0400,
    S_RESCAN  = 16'h0800,
    S_LINK    = 16'h1000,
    S_ENDP    = 16'h2000,
    S_DONE    = 16'h4000,
    S_BWAIT   = 16'h8000
  } state_t;

  // Phase within chain modes: pass 1 count, pass 2 link for allocate.
  state_t     state_r, state_nxt;
  logic       pass2_r, pass2_nxt;
  logic       wfin_end_r, wfin_end_nxt;
  logic [11:0] res_r, res_nxt, len_o_r, len_o_nxt;
  logic [1:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_result_value = res_r;
  assign out_chain_length = len_o_r;
  assign out_status = st_r;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    wfin_end_nxt = wfin_end_r;
    res_nxt = res_r;
    len_o_nxt = len_o_r;
    st_nxt = st_r;
    ov_nxt = 1'b0;
    ctl = '0;
    ctl.cmd = DP_NONE;
    ctl.wv = WV_INPUT;
    ctl.cp = CP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.cmd = DP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '0;
        len_o_nxt = '0;
        st_nxt = ST_OK;
        pass2_nxt = 1'b0;
        ctl.len_clr = 1'b1;
        ctl.found_clr = 1'b1;
        ctl.scan_init = 1'b1;
        case (sts.mode)
          MODE_WR_BYTE: begin
            ctl.cmd = DP_BYTE_WR;
            state_nxt = S_DONE;
          end
          MODE_RD_BYTE: begin
            ctl.cmd = DP_BYTE_RD;
            state_nxt = S_BYTE;
          end
          MODE_RD_ENTRY, MODE_WR_ENTRY: begin
            ctl.cmd = DP_RD_LO;
            state_nxt = S_RHI;
          end
          MODE_FREE, MODE_COLLECT: begin
            if (sts.cur_zero) state_nxt = S_DONE;
            else if (!sts.cur_data) begin
              st_nxt = ST_NOT_DATA;
              state_nxt = S_DONE;
            end else begin
              st_nxt = ST_BROKEN;
              state_nxt = S_RLO;
            end
          end
          MODE_ALLOC: begin
            if (sts.found_zero) state_nxt = S_DONE;
            else state_nxt = S_RESCAN;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_BYTE: begin
        res_nxt = byte_rd;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // cur holds scan pointer; check range and count before reading
        if (!sts.scan_in || sts.found_done) begin
          if (!pass2_r) begin
            if (sts.found_done) begin
              pass2_nxt = 1'b1;
              ctl.found_clr = 1'b1;
              ctl.scan_init = 1'b1;
              state_nxt = S_RESCAN;
            end else begin
              st_nxt = ST_NO_SPACE;
              state_nxt = S_DONE;
            end
          end else begin
            ctl.cp = CP_PREV;
            wfin_end_nxt = 1'b1;
            state_nxt = S_ENDP;
          end
        end else begin
          state_nxt = S_RLO;
        end
      end
      S_RESCAN: begin
        ctl.cp = CP_SCAN;
        state_nxt = S_SCAN;
      end
      S_RLO: begin
        if ((sts.mode == MODE_FREE || sts.mode == MODE_COLLECT)
            && (!sts.cur_data || sts.len_full)) begin
          state_nxt = S_DONE;  // status stays broken
          if (sts.mode == MODE_COLLECT) len_o_nxt = '0;
          else len_o_nxt = len_q;
        end else begin
          ctl.cmd = DP_RD_LO;
          state_nxt = S_RHI;
        end
      end
      S_RHI: begin
        ctl.cmd = DP_RD_HI;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        ctl.cmd = DP_CAP;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (sts.mode)
          MODE_RD_ENTRY: begin
            res_nxt = sts.entry;
            state_nxt = S_DONE;
          end
          MODE_WR_ENTRY: begin
            wfin_end_nxt = 1'b1;
            state_nxt = S_WLO;
          end
          MODE_FREE: begin
            ctl.len_inc = 1'b1;
            wfin_end_nxt = (sts.entry >= END_MIN) || (sts.entry == BAD_MARK);
            state_nxt = S_WLO;
          end
          MODE_COLLECT: begin
            ctl.len_inc = 1'b1;
            if (sts.entry >= END_MIN) begin
              st_nxt = ST_OK;
              res_nxt = cluster_q;
              len_o_nxt = len_q + 12'd1;
              state_nxt = S_DONE;
            end else if (sts.entry < 12'd2 || sts.entry == BAD_MARK) begin
              state_nxt = S_DONE;
            end else begin
              ctl.cp = CP_NEXT;
              state_nxt = S_RLO;
            end
          end
          MODE_ALLOC: begin
            if (sts.entry == '0) begin
              ctl.found_inc = 1'b1;
              if (pass2_r) begin
                state_nxt = S_LINK;
              end else begin
                ctl.scan_inc = 1'b1;
                state_nxt = S_RESCAN;
              end
            end else begin
              ctl.scan_inc = 1'b1;
              state_nxt = S_RESCAN;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_LINK: begin
        // first free one: record it; later ones: link prev -> scan
        if (len_q == '0) begin
          ctl.first_load = 1'b1;
          ctl.len_inc = 1'b1;
          ctl.prev_load = 1'b1;
          ctl.scan_inc = 1'b1;
          state_nxt = S_RESCAN;
        end else begin
          ctl.cp = CP_PREV;
          wfin_end_nxt = 1'b0;
          state_nxt = S_ENDP;
        end
      end
      S_ENDP: begin
        // cur = prev; write link or end mark after a fresh read of its bytes
        ctl.cmd = DP_RD_LO;
        state_nxt = S_WLO;
      end
      S_WLO: begin
        ctl.cmd = DP_RD_HI;
        state_nxt = S_WHI;
      end
      S_WHI: begin
        ctl.cmd = DP_WR_LO;
        ctl.wv = wsel();
        state_nxt = S_WFIN;
      end
      S_WFIN: begin
        ctl.cmd = DP_WR_HI;
        ctl.wv = wsel();
        case (sts.mode)
          MODE_FREE: begin
            if (wfin_end_r) begin
              st_nxt = ST_OK;
              len_o_nxt = len_q;
              state_nxt = S_DONE;
            end else begin
              ctl.cp = CP_NEXT;
              state_nxt = S_RLO;
            end
          end
          MODE_ALLOC: begin
            if (wfin_end_r) begin
              res_nxt = first_q;
              state_nxt = S_DONE;
            end else begin
              ctl.prev_load = 1'b1;
              ctl.len_inc = 1'b1;
              ctl.scan_inc = 1'b1;
              state_nxt = S_RESCAN;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_BWAIT;
      end
      S_BWAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  function automatic wv_sel_e wsel();
    wv_sel_e w;
    w = WV_INPUT;
    case (sts.mode)
      MODE_FREE:  w = WV_ZERO;
      MODE_ALLOC: w = wfin_end_r ? WV_END : WV_LINK;
      default:    w = WV_INPUT;
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      pass2_r <= 1'b0;
      wfin_end_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      pass2_r <= pass2_nxt;
      wfin_end_r <= wfin_end_nxt;
    end
    res_r <= res_nxt;
    len_o_r <= len_o_nxt;
    st_r <= st_nxt;
  end
endmodule

@@ design/fat12_cluster_chain_engine.sv @@
// Top level of the FAT12 cluster chain engine.
// Depends on fat12_pkg, fat12_ctrl and fat12_datapath.
//
// Command-style block: a beat is taken when start is high and busy is low;
// exactly one result follows, shown for one cycle with out_valid high, and
// the receiver cannot stall it. Items are worked one at a time through one
// byte-wide single-port table memory. An entry write reads both bytes, then
// writes both for the shared nibble. Collect reads each chain link, free
// reads and clears each link; allocate scans every data cluster up to the
// last one it needs twice (count pass, link pass), reading the entry of each
// cluster visited and writing each link and the end mark. The table has no
// reset; load it by byte writes before reading. total_clusters is written
// through the cfg channel, which is always ready; write it only while the
// block is idle.
module fat12_cluster_chain_engine import fat12_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [12:0] in_byte_addr,
  input  logic [11:0] in_cluster,
  input  logic [11:0] in_value,
  input  logic [11:0] in_count,
  output logic        out_valid,
  output logic [11:0] out_result_value,
  output logic [11:0] out_chain_length,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_total_clusters
);
  logic [11:0] total_r;
  logic [11:0] total_eff;
  dp_ctl_t     ctl;
  dp_sts_t     sts;
  logic [11:0] byte_rd, cluster_q, first_q, len_q;

  assign cfg_ready = 1'b1;

  // Hold the register; clamp oversized counts to the FAT12 limit.
  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= 12'd2847;
    else if (cfg_valid) total_r <= cfg_total_clusters;
  end
  assign total_eff = (total_r > MAX_DATA) ? MAX_DATA : total_r;

  fat12_datapath #(.TABLE_BYTES(TABLE_BYTES)) u_dp (
    .clk, .ctl,
    .in_mode, .in_byte_addr, .in_cluster, .in_value, .in_count,
    .total(total_eff), .sts, .byte_rd, .cluster_q, .first_q, .len_q
  );

  fat12_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .byte_rd, .cluster_q, .first_q,
    .len_q, .ctl, .out_valid, .out_result_value, .out_chain_length,
    .out_status
  );

`ifndef SYNTHESIS
  // A result is only shown while an item is in flight.
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without item");
  // Results are single-cycle strobes.
  a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");
  // No-space never reports a length.
  a_nospace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_SPACE) |-> out_chain_length == '0)
    else $error("length on no space");
`endif
endmodule
